FILE: src/mlrrs_pkg.sv
// ----------------------------------------------------------------------------
// mlrrs_pkg
// Shared sizes, codes and helpers of the multilevel round-robin scheduler.
// ----------------------------------------------------------------------------
package mlrrs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 16;
    localparam int LEVELS      = 4;

    localparam int LEVEL_W = $clog2(LEVELS);
    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = LEVEL_W + IDX_W;
    localparam int MEM_DEPTH = LEVELS * (2 ** IDX_W);

    // fixed port field widths
    localparam int PID_FIELD_W  = 16;
    localparam int PRIO_FIELD_W = 3;
    localparam int QUANT_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    typedef logic [ID_WIDTH-1:0] t_id;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [OCC_W-1:0]    t_occ;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [QUANT_W-1:0]  t_quant;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_PRIO = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_EMPTY    = 2'd3;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    localparam t_level REG_QUANTUM0 = 2'd0;
    localparam t_level REG_QUANTUM1 = 2'd1;
    localparam t_level REG_QUANTUM2 = 2'd2;
    localparam t_level REG_QUANTUM3 = 2'd3;

    localparam t_quant QUANTUM0_RST = 8'd4;
    localparam t_quant QUANTUM1_RST = 8'd3;
    localparam t_quant QUANTUM2_RST = 8'd2;
    localparam t_quant QUANTUM3_RST = 8'd1;

    localparam t_level PTR_RST = t_level'(LEVELS - 1);

    // ring position after idx, wrapping at the queue depth
    function automatic t_idx next_idx(input t_idx idx);
        t_idx res;
        if (idx == t_idx'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

endpackage

FILE: src/multilevel_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_round_robin_scheduler_core
// Four priority FIFO queues of process handles served in rotating order.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_operation, i_process_id and
// i_priority_req. Add appends the handle to its level's queue; next advances
// the rotation pointer and serves the first non-empty level from there.
// Output channel: o_out_valid / i_out_stall with o_status, o_granted_id,
// o_quantum and o_any_waiting; one result per accepted item, in order.
// One item at a time: o_in_stall is high from acceptance until its result
// is loaded into the output register. A next probes one level per cycle
// with the shared occupancy compare (1 to 4 levels) and, on a hit, reads
// the queue memory through a register. A new item can be taken while the
// last result still waits. A stalled result holds; a finished item waits in
// the sequencer until the output register is free.
// Reset (synchronous, active low) empties all queues, sets the rotation
// pointer to level 3 and the quanta to 4, 3, 2, 1. The queue memory itself
// is not cleared; no entry is read before it is written.
// APB: quantum of level i at byte address 4*i, 8 bits, always ready.
// ----------------------------------------------------------------------------
module multilevel_round_robin_scheduler_core
    import mlrrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_operation,
    input  logic [PID_FIELD_W-1:0]  i_process_id,
    input  logic [PRIO_FIELD_W-1:0] i_priority_req,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [STATUS_W-1:0]     o_status,
    output logic [PID_FIELD_W-1:0]  o_granted_id,
    output logic [QUANT_W-1:0]      o_quantum,
    output logic                    o_any_waiting,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state;
    logic                    r_op;
    t_id                     r_pid;
    logic [PRIO_FIELD_W-1:0] r_prio;
    t_level                  r_ptr;
    t_level                  r_k;
    t_level                  r_lvl;
    t_idx                    r_head [LEVELS];
    t_idx                    r_tail [LEVELS];
    t_occ                    r_occ  [LEVELS];
    t_quant                  r_quant [LEVELS];

    t_status                 r_res_status;
    t_id                     r_res_grant;
    t_quant                  r_res_quant;

    logic                    r_out_valid;
    t_status                 r_out_status;
    t_id                     r_out_grant;
    t_quant                  r_out_quant;
    logic                    r_out_any;

    t_id                     r_mem [MEM_DEPTH];
    t_id                     r_rdata;

    logic                    w_in_accept;
    logic                    w_out_free;
    logic                    w_any;
    logic                    w_cfg_write;
    t_level                  w_scan_lvl;
    t_level                  w_add_lvl;
    logic                    w_scan_hit;
    logic                    w_mem_we;
    logic                    w_mem_re;
    logic [ADDR_W-1:0]       w_mem_waddr;
    logic [ADDR_W-1:0]       w_mem_raddr;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        w_any = 1'b0;
        for (int q = 0; q < LEVELS; q++) begin
            w_any = w_any | (r_occ[q] != '0);
        end
    end

    // shared probe unit: one level per cycle from the pointer onward
    assign w_scan_lvl = r_ptr + r_k;
    assign w_scan_hit = (r_occ[w_scan_lvl] != '0);
    assign w_add_lvl  = r_prio[LEVEL_W-1:0];

    assign w_mem_we    = (r_state == S_ADD) && (r_prio < PRIO_FIELD_W'(LEVELS))
                         && (r_occ[w_add_lvl] != t_occ'(QUEUE_DEPTH));
    assign w_mem_waddr = {w_add_lvl, r_tail[w_add_lvl]};
    assign w_mem_re    = (r_state == S_SCAN) && w_scan_hit;
    assign w_mem_raddr = {w_scan_lvl, r_head[w_scan_lvl]};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= r_pid;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_raddr];
        end
    end

    // sequencer and queue bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= PTR_RST;
            r_k     <= '0;
            for (int q = 0; q < LEVELS; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_occ[q]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (i_operation == OP_NEXT) begin
                            r_ptr   <= r_ptr + t_level'(1);
                            r_k     <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    if (w_mem_we) begin
                        r_tail[w_add_lvl] <= next_idx(r_tail[w_add_lvl]);
                        r_occ[w_add_lvl]  <= r_occ[w_add_lvl] + t_occ'(1);
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (w_scan_hit) begin
                        r_head[w_scan_lvl] <= next_idx(r_head[w_scan_lvl]);
                        r_occ[w_scan_lvl]  <= r_occ[w_scan_lvl] - t_occ'(1);
                        r_ptr              <= w_scan_lvl;
                        r_state            <= S_READ;
                    end else if (r_k == t_level'(LEVELS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + t_level'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item latch and result assembly
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op   <= i_operation;
            r_pid  <= t_id'(i_process_id);
            r_prio <= i_priority_req;
        end
        case (r_state)
            S_ADD: begin
                r_res_grant <= '0;
                r_res_quant <= '0;
                if (r_prio >= PRIO_FIELD_W'(LEVELS)) begin
                    r_res_status <= ST_BAD_PRIO;
                end else if (r_occ[w_add_lvl] == t_occ'(QUEUE_DEPTH)) begin
                    r_res_status <= ST_FULL;
                end else begin
                    r_res_status <= ST_OK;
                end
            end
            S_SCAN: begin
                r_lvl        <= w_scan_lvl;
                r_res_status <= ST_EMPTY;
                r_res_grant  <= '0;
                r_res_quant  <= '0;
            end
            S_READ: begin
                r_res_status <= ST_OK;
                r_res_grant  <= r_rdata;
                r_res_quant  <= r_quant[r_lvl];
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_grant  <= r_res_grant;
            r_out_quant  <= r_res_quant;
            r_out_any    <= w_any;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_granted_id  = PID_FIELD_W'(r_out_grant);
    assign o_quantum     = r_out_quant;
    assign o_any_waiting = r_out_any;

    // quantum registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant[REG_QUANTUM0] <= QUANTUM0_RST;
            r_quant[REG_QUANTUM1] <= QUANTUM1_RST;
            r_quant[REG_QUANTUM2] <= QUANTUM2_RST;
            r_quant[REG_QUANTUM3] <= QUANTUM3_RST;
        end else if (w_cfg_write) begin
            r_quant[paddr[APB_ADDR_W-1:2]] <= pwdata[QUANT_W-1:0];
        end
    end

    assign prdata = APB_DATA_W'(r_quant[paddr[APB_ADDR_W-1:2]]);
    assign pready = 1'b1;

`ifndef NO_ASSERTIONS
    // no queue ever holds more than its depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ[0] <= t_occ'(QUEUE_DEPTH)) && (r_occ[1] <= t_occ'(QUEUE_DEPTH))
        && (r_occ[2] <= t_occ'(QUEUE_DEPTH)) && (r_occ[3] <= t_occ'(QUEUE_DEPTH)))
        else $error("queue occupancy above depth");

    // an accepted item blocks the input until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // nothing waiting means every queue is empty
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> !o_any_waiting)
        else $error("empty result while a process waits");

    // a grant result only comes from a next item
    a_grant_from_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_op == OP_NEXT))
        else $error("memory read outside a next item");
`endif

endmodule
